[hdl/assert_macros.svh]
// assertion macros shared by the routing table rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/krt_pkg.sv]
// shared types and constants for the k-bucket routing table
// used by krt_row_mem and kbucket_routing_table; no dependencies
`timescale 1ns / 1ps

package krt_pkg;

    localparam int ID_W     = 64;
    localparam int TIME_W   = 48;
    localparam int FAIL_W   = 8;
    localparam int BKT_W    = 6;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 3;

    localparam logic [FAIL_W-1:0] FAIL_MAX = 8'h80 + 8'h7F;

    localparam logic [1:0] CMD_OBSERVE = 2'd0;
    localparam logic [1:0] CMD_ALIVE   = 2'd1;
    localparam logic [1:0] CMD_FAILED  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_SELF      = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REPLACED  = 3'd3,
        ST_DROPPED   = 3'd4,
        ST_MARKED    = 3'd5,
        ST_IGNORED   = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ID_W-1:0]   node_id;
        logic [TIME_W-1:0] now_ms;
        logic [BKT_W-1:0]  target_bucket;
        logic [SLOT_W-1:0] target_slot;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [BKT_W-1:0]  bucket_index;
        logic [SLOT_W-1:0] slot_index;
        logic [ID_W-1:0]   evicted_id;
    } rsp_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BKT_W-1:0] rd_addr;
        logic [BKT_W-1:0] wr_addr;
    } mem_ctrl_t;

endpackage

[hdl/kbucket_routing_table.sv]
// k-bucket routing table: command sequencer around one row-per-bucket memory
// steps: self, bad command or bad bucket end in S_DIST; a mark ends in S_EVAL;
// observe runs S_LZC, S_EVAL, and on a full bucket S_SCAN (oldest-slot scan, one slot
// a cycle), S_DECIDE. requests are taken only when idle; each does at most one row
// read and at most one row write, never in the same cycle. results cannot be stalled
// reset: local id clears, all buckets read empty at once (row valid flops), no sweep
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kbucket_routing_table #(
    parameter int ID_BITS          = 64,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  krt_pkg::req_t             request,
    output logic                      done,
    output krt_pkg::rsp_t             result,
    input  logic                      cfg_we,
    input  logic [krt_pkg::ID_W-1:0]  cfg_wdata
);

    localparam int S      = SLOTS_PER_BUCKET;
    localparam int SL_W   = (S > 1) ? $clog2(S) : 1;
    localparam int FILL_W = $clog2(S + 1);
    localparam int PAD    = krt_pkg::ID_W - ID_BITS;
    localparam int ROW_W  = FILL_W + S * (ID_BITS + krt_pkg::TIME_W + krt_pkg::FAIL_W);

    typedef struct packed {
        logic [FILL_W-1:0]                       fill;
        logic [S-1:0][ID_BITS-1:0]               ids;
        logic [S-1:0][krt_pkg::TIME_W-1:0]       seen;
        logic [S-1:0][krt_pkg::FAIL_W-1:0]       fails;
    } row_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIST   = 6'b000010,
        S_LZC    = 6'b000100,
        S_EVAL   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DECIDE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ID_BITS-1:0]               local_reg;
    logic [1:0]                       cmd_reg;
    logic [ID_BITS-1:0]               id_reg;
    logic [ID_BITS-1:0]               dist_reg;
    logic [krt_pkg::TIME_W-1:0]       now_reg;
    logic [krt_pkg::BKT_W-1:0]        tb_reg;
    logic [krt_pkg::SLOT_W-1:0]       ts_reg;

    logic [7:0]                       grp_nz_reg, grp_nz_next;
    logic [7:0][2:0]                  grp_lz_reg, grp_lz_next;
    logic [krt_pkg::BKT_W-1:0]        bucket_reg, bucket_next;
    logic [SL_W-1:0]                  scan_reg, scan_next;
    logic [SL_W-1:0]                  oldest_reg, oldest_next;

    krt_pkg::rsp_t                    res_reg, res_next;
    logic                             done_reg, done_next;

    krt_pkg::mem_ctrl_t               mem_ctrl;
    logic [ROW_W-1:0]                 rd_data;
    logic                             rd_valid;
    row_t                             row_q;
    row_t                             new_row;

    logic                             accept;
    logic [krt_pkg::ID_W-1:0]         dist_al;
    logic [FILL_W-1:0]                fill;
    logic [S-1:0]                     hit;
    logic [SL_W-1:0]                  hit_idx;
    logic [SL_W-1:0]                  mark_idx;
    logic [SL_W-1:0]                  fill_idx;
    logic                             tb_ok;
    logic                             ts_ok;

    function automatic logic [2:0] lzc8(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int b = 0; b < 8; b++)
        begin
            if (v[b])
            begin
                n = 3'(7 - b);
            end
        end
        return n;
    endfunction

    krt_row_mem #(
        .DEPTH (ID_BITS),
        .ROW_W (ROW_W)
    ) u_row_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mem_ctrl),
        .wr_data  (new_row),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign result  = res_reg;
    assign row_q   = row_t'(rd_data);

    // distance left-aligned in 64 bits, then split into byte groups
    assign dist_al = krt_pkg::ID_W'(dist_reg) << PAD;

    assign fill     = rd_valid ? row_q.fill : '0;
    assign fill_idx = SL_W'(fill);
    assign mark_idx = SL_W'(ts_reg);
    assign tb_ok    = (int'(tb_reg) < ID_BITS);
    assign ts_ok    = (int'(ts_reg) < S) && (int'(ts_reg) < int'(fill));

    always_comb
    begin
        hit     = '0;
        hit_idx = '0;
        for (int i = 0; i < S; i++)
        begin
            hit[i] = (i < int'(fill)) && (row_q.ids[i] == id_reg);
        end
        for (int i = S - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = SL_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        grp_nz_next = grp_nz_reg;
        grp_lz_next = grp_lz_reg;
        bucket_next = bucket_reg;
        scan_next   = scan_reg;
        oldest_next = oldest_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        mem_ctrl    = '0;
        new_row     = row_q;

        mem_ctrl.wr_addr = bucket_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIST;
                end
            end

            S_DIST:
            begin
                if (cmd_reg == krt_pkg::CMD_OBSERVE)
                begin
                    if (dist_reg == '0)
                    begin
                        res_next   = '{krt_pkg::ST_SELF, '0, '0, '0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        for (int g = 0; g < 8; g++)
                        begin
                            grp_nz_next[g] = |dist_al[63 - 8 * g -: 8];
                            grp_lz_next[g] = lzc8(dist_al[63 - 8 * g -: 8]);
                        end
                        state_next = S_LZC;
                    end
                end
                else if ((cmd_reg == krt_pkg::CMD_ALIVE || cmd_reg == krt_pkg::CMD_FAILED)
                         && tb_ok)
                begin
                    mem_ctrl.rd_en   = 1'b1;
                    mem_ctrl.rd_addr = tb_reg;
                    bucket_next      = tb_reg;
                    state_next       = S_EVAL;
                end
                else
                begin
                    res_next   = '{krt_pkg::ST_IGNORED, tb_reg, ts_reg, '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_LZC:
            begin
                // most significant nonzero byte group gives the bucket
                for (int g = 7; g >= 0; g--)
                begin
                    if (grp_nz_reg[g])
                    begin
                        bucket_next = {3'(g), grp_lz_reg[g]};
                    end
                end
                mem_ctrl.rd_en   = 1'b1;
                mem_ctrl.rd_addr = bucket_next;
                state_next       = S_EVAL;
            end

            S_EVAL:
            begin
                if (cmd_reg == krt_pkg::CMD_OBSERVE)
                begin
                    if (|hit)
                    begin
                        new_row.seen[hit_idx] = now_reg;
                        mem_ctrl.wr_en = 1'b1;
                        res_next   = '{krt_pkg::ST_REFRESHED, bucket_reg,
                                       krt_pkg::SLOT_W'(hit_idx), '0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (int'(fill) < S)
                    begin
                        new_row.ids[fill_idx]   = id_reg;
                        new_row.seen[fill_idx]  = now_reg;
                        new_row.fails[fill_idx] = '0;
                        new_row.fill            = fill + FILL_W'(1);
                        mem_ctrl.wr_en = 1'b1;
                        res_next   = '{krt_pkg::ST_INSERTED, bucket_reg,
                                       krt_pkg::SLOT_W'(fill), '0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oldest_next = '0;
                        scan_next   = SL_W'(1);
                        state_next  = (S > 1) ? S_SCAN : S_DECIDE;
                    end
                end
                else
                begin
                    if (ts_ok)
                    begin
                        if (cmd_reg == krt_pkg::CMD_ALIVE)
                        begin
                            new_row.seen[mark_idx]  = now_reg;
                            new_row.fails[mark_idx] = '0;
                        end
                        else if (row_q.fails[mark_idx] != krt_pkg::FAIL_MAX)
                        begin
                            new_row.fails[mark_idx] = row_q.fails[mark_idx] + 8'd1;
                        end
                        mem_ctrl.wr_en = 1'b1;
                        res_next = '{krt_pkg::ST_MARKED, tb_reg, ts_reg, '0};
                    end
                    else
                    begin
                        res_next = '{krt_pkg::ST_IGNORED, tb_reg, ts_reg, '0};
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // strict less-than keeps the lowest index on ties
                if (row_q.seen[scan_reg] < row_q.seen[oldest_reg])
                begin
                    oldest_next = scan_reg;
                end
                if (scan_reg == SL_W'(S - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_next = scan_reg + SL_W'(1);
                end
            end

            S_DECIDE:
            begin
                if (row_q.fails[oldest_reg] != '0)
                begin
                    new_row.ids[oldest_reg]   = id_reg;
                    new_row.seen[oldest_reg]  = now_reg;
                    new_row.fails[oldest_reg] = '0;
                    mem_ctrl.wr_en = 1'b1;
                    res_next = '{krt_pkg::ST_REPLACED, bucket_reg,
                                 krt_pkg::SLOT_W'(oldest_reg),
                                 krt_pkg::ID_W'(row_q.ids[oldest_reg])};
                end
                else
                begin
                    res_next = '{krt_pkg::ST_DROPPED, bucket_reg,
                                 krt_pkg::SLOT_W'(oldest_reg), '0};
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            local_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                local_reg <= cfg_wdata[ID_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= request.command;
            id_reg   <= request.node_id[ID_BITS-1:0];
            dist_reg <= request.node_id[ID_BITS-1:0] ^ local_reg;
            now_reg  <= request.now_ms;
            tb_reg   <= request.target_bucket;
            ts_reg   <= request.target_slot;
        end
        grp_nz_reg <= grp_nz_next;
        grp_lz_reg <= grp_lz_next;
        bucket_reg <= bucket_next;
        scan_reg   <= scan_next;
        oldest_reg <= oldest_next;
        res_reg    <= res_next;
    end

    `ASSERT_IMP(a_done_after_work, done, $past(busy))
    `ASSERT_IMP(a_no_rw_collision, mem_ctrl.rd_en, !mem_ctrl.wr_en)
    `ASSERT_NXT(a_write_gives_result, mem_ctrl.wr_en, done)
    `ASSERT_IMP(a_evicted_only_replaced,
                done && (result.status != krt_pkg::ST_REPLACED), result.evicted_id == '0)

endmodule

[hdl/krt_row_mem.sv]
// bucket row memory: one row per bucket, registered read, plus row valid bits
// depends on krt_pkg for the control struct
`timescale 1ns / 1ps

module krt_row_mem #(
    parameter int DEPTH = 64,
    parameter int ROW_W = 964
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  krt_pkg::mem_ctrl_t   ctrl,
    input  logic [ROW_W-1:0]     wr_data,
    output logic [ROW_W-1:0]     rd_data,
    output logic                 rd_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ROW_W-1:0] row_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;

    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;

    assign rd_idx = ctrl.rd_addr[AW-1:0];
    assign wr_idx = ctrl.wr_addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            row_mem[wr_idx] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg  <= row_mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    // a row that was never written reads as an empty bucket
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule
